// ----- rtl/core/signed_restoring_divider_core_macros.svh -----
// Assertion macros shared by the divider core checkers.
`ifndef SIGNED_RESTORING_DIVIDER_CORE_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_CORE_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define SRDIV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("divider check failed: implication");

// Checks that a condition is followed by another after the pipeline latency.
`define SRDIV_ASSERT_LAT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##LAT (cons)) \
    else $error("divider check failed: latency");

`endif

// ----- rtl/core/srdiv_pkg.sv -----
// Package with shared constants and types for the signed divider core.
package srdiv_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  // Control flags that travel down the pipeline with each operand pair.
  typedef struct packed {
    logic valid;
    logic neg;
    logic dbz;
    logic a_neg;
  } ctrl_t;

endpackage

// ----- rtl/core/srdiv_pre.sv -----
// Input stage: registers operand magnitudes and sign flags.
module srdiv_pre #(
  parameter int DATA_WIDTH = srdiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic [DATA_WIDTH-1:0] na,
  output logic [DATA_WIDTH-1:0] nb,
  output srdiv_pkg::ctrl_t      ctrl
);
  import srdiv_pkg::*;

  logic a_neg;
  logic b_neg;

  assign a_neg = dividend[DATA_WIDTH-1];
  assign b_neg = divisor[DATA_WIDTH-1];

  // Only the valid bit is reset; the data fields simply follow the inputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= load;
    end
    na         <= a_neg ? (~dividend + 1'b1) : dividend;
    nb         <= b_neg ? (~divisor + 1'b1) : divisor;
    ctrl.neg   <= a_neg ^ b_neg;
    ctrl.dbz   <= (divisor == '0);
    ctrl.a_neg <= a_neg;
  end

endmodule

// ----- rtl/core/srdiv_step.sv -----
// One restoring division step: shift in a dividend bit, trial subtract, register.
module srdiv_step #(
  parameter int DATA_WIDTH = srdiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] dvd_in,
  input  logic [DATA_WIDTH-1:0] q_in,
  input  logic [DATA_WIDTH-1:0] nb_in,
  input  srdiv_pkg::ctrl_t      ctrl_in,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] dvd_out,
  output logic [DATA_WIDTH-1:0] q_out,
  output logic [DATA_WIDTH-1:0] nb_out,
  output srdiv_pkg::ctrl_t      ctrl_out
);
  import srdiv_pkg::*;

  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH:0] diff;
  logic                fits;

  // The remainder stays below the divisor, so one extra bit holds the shifted value.
  assign trial = {rem_in, dvd_in[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, nb_in};
  assign fits  = ~diff[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    rem_out        <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    dvd_out        <= {dvd_in[DATA_WIDTH-2:0], 1'b0};
    q_out          <= {q_in[DATA_WIDTH-2:0], fits};
    nb_out         <= nb_in;
    ctrl_out.neg   <= ctrl_in.neg;
    ctrl_out.dbz   <= ctrl_in.dbz;
    ctrl_out.a_neg <= ctrl_in.a_neg;
  end

endmodule

// ----- rtl/core/srdiv_post.sv -----
// Output stage: sign correction, saturation and the divide-by-zero result.
module srdiv_post #(
  parameter int DATA_WIDTH = srdiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DATA_WIDTH-1:0] q_in,
  input  srdiv_pkg::ctrl_t      ctrl_in,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic                  div_by_zero
);
  import srdiv_pkg::*;

  logic [DATA_WIDTH-1:0] max_pos;
  logic [DATA_WIDTH-1:0] min_neg;
  logic [DATA_WIDTH-1:0] res;

  assign max_pos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  assign min_neg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // The magnitude never exceeds the most negative value, so only the
  // positive path can overflow.
  always_comb begin
    if (ctrl_in.dbz) begin
      res = ctrl_in.a_neg ? min_neg : max_pos;
    end else if (ctrl_in.neg) begin
      res = ~q_in + 1'b1;
    end else if (q_in[DATA_WIDTH-1]) begin
      res = max_pos;
    end else begin
      res = q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    quotient    <= res;
    div_by_zero <= ctrl_in.dbz;
  end

endmodule

// ----- rtl/core/signed_restoring_divider_core.sv -----
// The start transfer passes through the input stage, the restoring steps and the output stage to the done strobe.
// Throughput: one division per cycle; busy stays low, so start may be high every cycle.
// One restoring step per pipeline stage sets the latency, plus an input and an output stage.
// Reset clears all valid bits; operations in flight are dropped and no strobe follows.
// Top level of the pipelined signed saturating divider.
module signed_restoring_divider_core #(
  parameter int DATA_WIDTH = srdiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         div_by_zero
);
  import srdiv_pkg::*;

  logic [DATA_WIDTH-1:0] rem_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dvd_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] q_s    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nb_s   [0:DATA_WIDTH];
  ctrl_t                 ctrl_s [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] q_final;

  assign busy     = 1'b0;
  assign rem_s[0] = '0;
  assign q_s[0]   = '0;

  srdiv_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
    .clk      (clk),
    .rst      (rst),
    .load     (start & ~busy),
    .dividend (dividend),
    .divisor  (divisor),
    .na       (dvd_s[0]),
    .nb       (nb_s[0]),
    .ctrl     (ctrl_s[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    srdiv_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
      .clk      (clk),
      .rst      (rst),
      .rem_in   (rem_s[i]),
      .dvd_in   (dvd_s[i]),
      .q_in     (q_s[i]),
      .nb_in    (nb_s[i]),
      .ctrl_in  (ctrl_s[i]),
      .rem_out  (rem_s[i+1]),
      .dvd_out  (dvd_s[i+1]),
      .q_out    (q_s[i+1]),
      .nb_out   (nb_s[i+1]),
      .ctrl_out (ctrl_s[i+1])
    );
  end

  srdiv_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk         (clk),
    .rst         (rst),
    .q_in        (q_s[DATA_WIDTH]),
    .ctrl_in     (ctrl_s[DATA_WIDTH]),
    .done        (done),
    .quotient    (q_final),
    .div_by_zero (div_by_zero)
  );

  assign quotient = q_final;

  // The final remainder, the spent dividend and the divisor magnitude are not needed past the last step.
  logic unused_tail;
  assign unused_tail = ^{rem_s[DATA_WIDTH], dvd_s[DATA_WIDTH], nb_s[DATA_WIDTH]};

endmodule

// ----- rtl/core/srdiv_checker.sv -----
// Port-level checker for the divider core, with its bind statement.
`include "signed_restoring_divider_core_macros.svh"

module srdiv_checker #(
  parameter int DATA_WIDTH = srdiv_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [DATA_WIDTH-1:0] divisor,
  input logic                  done,
  input logic                  div_by_zero
);
  import srdiv_pkg::*;

  localparam int LAT = DATA_WIDTH + 2;

  // Every transfer in produces exactly one strobe after the fixed latency.
  `SRDIV_ASSERT_LAT(a_strobe_follows, start && !busy, done)
  `SRDIV_ASSERT_IMP(a_strobe_has_source, done, $past(start && !busy, LAT))
  // The zero flag must match the divisor of the same operation.
  `SRDIV_ASSERT_IMP(a_dbz_matches, done, div_by_zero == $past(divisor == '0, LAT))
  `SRDIV_ASSERT_IMP(a_never_busy, 1'b1, !busy)

endmodule

bind signed_restoring_divider_core srdiv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_srdiv_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .divisor     (divisor),
  .done        (done),
  .div_by_zero (div_by_zero)
);

// ----- verif/tb_signed_restoring_divider_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the pipelined signed saturating divider core.
module tb_signed_restoring_divider_core;
  import srdiv_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  // Pipeline latency from the start transfer to the done strobe.
  localparam int LAT = DW + 2;
  localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam int NUM_RANDOM = 1625;

  typedef enum int {
    OPS_FULL,
    OPS_SMALL,
    OPS_BIG_BY_SMALL,
    OPS_EXACT,
    OPS_ZERO_DIV,
    OPS_EXTREME
  } operand_kind_t;

  typedef struct {
    logic [DW-1:0] quo;
    logic          dbz;
  } quotient_exp_t;

  class quotient_scoreboard;
    quotient_exp_t pending_q[$];
    int errors      = 0;
    int transfers   = 0;
    int checked     = 0;
    int zero_divs   = 0;
    int saturations = 0;
    int negatives   = 0;

    // Restoring division on the operand magnitudes, then sign fix-up and clamp.
    function void divide(input logic [DW-1:0] a, input logic [DW-1:0] b,
                         output logic [DW-1:0] q_out, output logic dbz);
      logic [DW-1:0] mag_a;
      logic [DW-1:0] mag_b;
      logic [DW-1:0] q;
      logic [DW:0]   rem;
      logic          neg;
      mag_a = a[DW-1] ? (~a + 1'b1) : a;
      mag_b = b[DW-1] ? (~b + 1'b1) : b;
      dbz = 1'b0;
      if (b == '0) begin
        q_out = a[DW-1] ? MIN_NEG : MAX_POS;
        dbz = 1'b1;
        return;
      end
      rem = '0;
      q = '0;
      for (int i = DW - 1; i >= 0; i--) begin
        rem = {rem[DW-1:0], mag_a[i]};
        if (rem >= {1'b0, mag_b}) begin
          rem = rem - {1'b0, mag_b};
          q[i] = 1'b1;
        end
      end
      neg = (a[DW-1] != b[DW-1]) && (a != '0);
      if (neg) begin
        if (q > MIN_NEG) q = MIN_NEG;
        q_out = ~q + 1'b1;
      end else begin
        if (q > MAX_POS) q = MAX_POS;
        q_out = q;
      end
    endfunction

    function void note_operands(logic [DW-1:0] a, logic [DW-1:0] b);
      quotient_exp_t e;
      divide(a, b, e.quo, e.dbz);
      transfers++;
      if (e.dbz) zero_divs++;
      if (a == MIN_NEG && b == '1) saturations++;
      if (e.quo[DW-1] && !e.dbz) negatives++;
      pending_q.insert(pending_q.size(), e);
    endfunction

    function void check_result(logic [DW-1:0] q, logic dbz);
      quotient_exp_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: quotient %h div_by_zero %b",
                 $time, q, dbz);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (q !== e.quo) begin
        $display("%0t: quotient mismatch: expected %h actual %h", $time, e.quo, q);
        errors++;
      end
      if (dbz !== e.dbz) begin
        $display("%0t: div_by_zero mismatch: expected %b actual %b", $time, e.dbz, dbz);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [DW-1:0] dividend;
  logic signed [DW-1:0] divisor;
  logic                 done;
  logic signed [DW-1:0] quotient;
  logic                 div_by_zero;

  quotient_scoreboard sb = new();

  signed_restoring_divider_core #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .dividend   (dividend),
    .divisor    (divisor),
    .done       (done),
    .quotient   (quotient),
    .div_by_zero(div_by_zero)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_operands(dividend, divisor);
      if (done) sb.check_result(quotient, div_by_zero);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
                         input bit idle_on);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 21) begin
        start = 1'b0;
        dividend = $urandom;
        divisor = $urandom;
        @(negedge clk);
      end
    end
    start = 1'b1;
    dividend = a;
    divisor = b;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic logic [DW-1:0] pick_extreme();
    case ($urandom_range(0, 8))
      0: return '0;
      1: return 1;
      2: return '1;
      3: return MAX_POS;
      4: return MIN_NEG;
      5: return MAX_POS - 1'b1;
      6: return MIN_NEG + 1'b1;
      7: return 2;
      default: return -2;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_small();
    return int'($urandom_range(0, 128)) - 64;
  endfunction

  task automatic pick_operands(output logic [DW-1:0] a, output logic [DW-1:0] b);
    operand_kind_t kind;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) kind = OPS_FULL;
    else if (roll < 55) kind = OPS_SMALL;
    else if (roll < 70) kind = OPS_BIG_BY_SMALL;
    else if (roll < 80) kind = OPS_EXACT;
    else if (roll < 88) kind = OPS_ZERO_DIV;
    else kind = OPS_EXTREME;
    case (kind)
      OPS_FULL: begin
        a = $urandom;
        b = $urandom;
      end
      OPS_SMALL: begin
        a = pick_small();
        b = pick_small();
      end
      OPS_BIG_BY_SMALL: begin
        a = $urandom;
        b = pick_small();
      end
      OPS_EXACT: begin
        b = pick_small();
        a = b * (int'($urandom_range(0, 20000)) - 10000);
      end
      OPS_ZERO_DIV: begin
        a = $urandom_range(0, 1) ? pick_extreme() : $urandom;
        b = '0;
      end
      default: begin
        a = $urandom_range(0, 3) != 0 ? pick_extreme() : $urandom;
        b = $urandom_range(0, 3) != 0 ? pick_extreme() : pick_small();
      end
    endcase
  endtask

  initial begin
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    rst = 1'b1;
    start = 1'b0;
    dividend = '0;
    divisor = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Field extremes, every sign combination, overflow and division by zero.
    send_op(0, 1, 1'b1);
    send_op(1, 1, 1'b1);
    send_op(-1, 1, 1'b1);
    send_op(MAX_POS, 1, 1'b1);
    send_op(MIN_NEG, 1, 1'b1);
    send_op(MIN_NEG, -1, 1'b1);
    send_op(MAX_POS, -1, 1'b1);
    send_op(MIN_NEG, MIN_NEG, 1'b1);
    send_op(MAX_POS, MAX_POS, 1'b1);
    send_op(MIN_NEG, MAX_POS, 1'b1);
    send_op(7, 2, 1'b1);
    send_op(-7, 2, 1'b1);
    send_op(7, -2, 1'b1);
    send_op(-7, -2, 1'b1);
    send_op(0, -5, 1'b1);
    send_op(5, 0, 1'b1);
    send_op(-5, 0, 1'b1);
    send_op(0, 0, 1'b1);
    send_op(MIN_NEG, 0, 1'b1);
    send_op(MAX_POS, 0, 1'b1);
    send_op(1, MAX_POS, 1'b1);
    send_op(-1, MIN_NEG, 1'b1);
    send_op(3, MIN_NEG, 1'b1);
    send_op(MIN_NEG, 2, 1'b1);
    send_op(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick_operands(a, b);
      // One long back-to-back burst keeps the pipeline completely full.
      send_op(a, b, !(n >= 500 && n < 850));
    end
    start = 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (LAT + 8) @(posedge clk);

    $display("Ran %0d divisions back to back and with gaps: %0d by zero, %0d overflowing,",
             sb.transfers, sb.zero_divs, sb.saturations);
    $display("%0d with negative quotients; %0d results compared, %0d mismatches.",
             sb.negatives, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Timed out with %0d results outstanding.", sb.pending());
    $display("status: fail");
    $finish;
  end

endmodule
